/* hw/rtl/assert_macros.svh */
// assertion macros shared by the flight phase sequencer rtl
// every macro expects clk_i and rst_ni in the scope of the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define FPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fps_pkg.sv */
// types, codes and interval tables of the flight phase sequencer
// used by fps_cfg, fps_step and flight_phase_sequencer
package fps_pkg;

  // width of the wrapping millisecond time
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned IVL_W     = 11;

  // flight phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ARMED   = 3'd1;
  localparam logic [2:0] PH_POWERED = 3'd2;
  localparam logic [2:0] PH_COAST   = 3'd3;
  localparam logic [2:0] PH_DESCENT = 3'd4;
  localparam logic [2:0] PH_CHUTE   = 3'd5;
  localparam logic [2:0] PH_LANDED  = 3'd6;

  // ground command codes
  localparam logic [7:0] CMD_ARM      = 8'd108;
  localparam logic [7:0] CMD_ZERO_ATT = 8'd109;
  localparam logic [7:0] CMD_BARO_CAL = 8'd98;
  localparam logic [7:0] CMD_RESTART  = 8'd116;
  localparam logic [7:0] CMD_BEEP     = 8'd119;
  localparam logic [7:0] CMD_SERIAL   = 8'd115;

  // register indexes on the config port
  localparam logic [2:0] REG_LIFTOFF_ACCEL = 3'd0;
  localparam logic [2:0] REG_BURNOUT_ACCEL = 3'd1;
  localparam logic [2:0] REG_APOGEE_VEL    = 3'd2;
  localparam logic [2:0] REG_CHUTE_ACCEL   = 3'd3;
  localparam logic [2:0] REG_LANDING_VEL   = 3'd4;
  localparam logic [2:0] REG_CONFIRM_LIMIT = 3'd5;
  localparam logic [2:0] REG_DETECT_GAP    = 3'd6;

  localparam int unsigned PADDR_W = 5;

  typedef struct packed {
    logic        [23:0] liftoff_accel;
    logic        [23:0] burnout_accel;
    logic signed [23:0] apogee_vel;
    logic        [23:0] chute_accel;
    logic signed [23:0] landing_vel;
    logic        [3:0]  confirm_limit;
    logic        [15:0] detect_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [4:0] tally_now;
    logic       take_sample;
    logic       send_telemetry;
    logic       send_serial;
    logic       serial_active;
    logic       restart_req;
    logic       zero_attitude_req;
    logic       baro_cal_req;
    logic       beep_req;
  } res_t;

  typedef struct packed {
    logic [IVL_W-1:0] telem;
    logic [IVL_W-1:0] sample;
    logic [IVL_W-1:0] serial;
  } ivl_t;

  // interval table by phase, in ms
  function automatic ivl_t phase_ivl(input logic [2:0] ph);
    ivl_t r;
    case (ph)
      PH_IDLE:    r = '{telem: 11'd1000, sample: 11'd100, serial: 11'd200};
      PH_ARMED:   r = '{telem: 11'd50,   sample: 11'd20,  serial: 11'd100};
      PH_POWERED,
      PH_COAST,
      PH_DESCENT,
      PH_CHUTE:   r = '{telem: 11'd20,   sample: 11'd20,  serial: 11'd100};
      default:    r = '{telem: 11'd20,   sample: 11'd100, serial: 11'd200};
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/fps_cfg.sv */
// threshold registers of the flight phase sequencer behind an apb-style port
// depends on fps_pkg
module fps_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fps_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output fps_pkg::cfg_t                cfg_o
);
  import fps_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_LIFTOFF_ACCEL: cfg_d.liftoff_accel = pwdata[23:0];
        REG_BURNOUT_ACCEL: cfg_d.burnout_accel = pwdata[23:0];
        REG_APOGEE_VEL:    cfg_d.apogee_vel    = pwdata[23:0];
        REG_CHUTE_ACCEL:   cfg_d.chute_accel   = pwdata[23:0];
        REG_LANDING_VEL:   cfg_d.landing_vel   = pwdata[23:0];
        REG_CONFIRM_LIMIT: cfg_d.confirm_limit = pwdata[3:0];
        REG_DETECT_GAP:    cfg_d.detect_gap_ms = pwdata[15:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.liftoff_accel <= 24'd5120;
      cfg_q.burnout_accel <= 24'd512;
      cfg_q.apogee_vel    <= 24'sd1280;
      cfg_q.chute_accel   <= 24'd1536;
      cfg_q.landing_vel   <= 24'sd768;
      cfg_q.confirm_limit <= 4'd4;
      cfg_q.detect_gap_ms <= 16'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux, raw register bits
  always_comb begin
    case (reg_idx)
      REG_LIFTOFF_ACCEL: prdata = {8'd0, cfg_q.liftoff_accel};
      REG_BURNOUT_ACCEL: prdata = {8'd0, cfg_q.burnout_accel};
      REG_APOGEE_VEL:    prdata = {8'd0, cfg_q.apogee_vel};
      REG_CHUTE_ACCEL:   prdata = {8'd0, cfg_q.chute_accel};
      REG_LANDING_VEL:   prdata = {8'd0, cfg_q.landing_vel};
      REG_CONFIRM_LIMIT: prdata = {28'd0, cfg_q.confirm_limit};
      REG_DETECT_GAP:    prdata = {16'd0, cfg_q.detect_gap_ms};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/fps_step.sv */
// one control loop pass: timer strobes, commands and phase debounce
// holds the sequencer state; depends on fps_pkg and assert_macros.svh
`include "assert_macros.svh"

module fps_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_en_i,
  input  logic [fps_pkg::TIME_BITS-1:0] time_ms_i,
  input  logic [23:0]                   accel_mag_i,
  input  logic signed [23:0]            vert_vel_i,
  input  logic [7:0]                    command_i,
  input  fps_pkg::cfg_t                 cfg_i,
  output fps_pkg::res_t                 res_o
);
  import fps_pkg::*;

  logic [2:0]            phase_q, phase_d, phase_cmd;
  logic [4:0]            tally_q, tally_d;
  logic                  serial_en_q, serial_en_d;
  logic [TIME_BITS-1:0]  sample_mark_q, sample_mark_d;
  logic [TIME_BITS-1:0]  telem_mark_q, telem_mark_d;
  logic [TIME_BITS-1:0]  serial_mark_q, serial_mark_d;
  logic [TIME_BITS-1:0]  last_time_q;
  logic [23:0]           held_accel_q, held_accel_d;
  logic signed [23:0]    held_vel_q, held_vel_d;
  logic [TIME_BITS-1:0]  dt_sample, dt_telem, dt_serial, dt_gap;
  ivl_t                  ivl;
  logic                  smp, tel, ser;
  logic                  zat, bcal, rst_req, beep;
  logic                  gap_ok, cond, run;
  logic [4:0]            limit;

  // wrapped time since each mark
  assign ivl       = phase_ivl(phase_q);
  assign dt_sample = time_ms_i - sample_mark_q;
  assign dt_telem  = time_ms_i - telem_mark_q;
  assign dt_serial = time_ms_i - serial_mark_q;
  assign dt_gap    = time_ms_i - last_time_q;

  // timer strobes, phase at start of pass
  assign smp    = dt_sample > TIME_BITS'(ivl.sample);
  assign ser    = (dt_serial > TIME_BITS'(ivl.serial)) & serial_en_q;
  assign tel    = dt_telem > TIME_BITS'(ivl.telem);
  assign gap_ok = dt_gap < TIME_BITS'(cfg_i.detect_gap_ms);

  assign sample_mark_d = smp ? time_ms_i : sample_mark_q;
  assign serial_mark_d = ser ? time_ms_i : serial_mark_q;
  assign telem_mark_d  = tel ? time_ms_i : telem_mark_q;
  assign held_accel_d  = smp ? accel_mag_i : held_accel_q;
  assign held_vel_d    = smp ? vert_vel_i : held_vel_q;

  // command decode
  always_comb begin
    phase_cmd   = phase_q;
    serial_en_d = serial_en_q;
    zat         = 1'b0;
    bcal        = 1'b0;
    rst_req     = 1'b0;
    beep        = 1'b0;
    case (command_i)
      CMD_ARM:      phase_cmd   = PH_ARMED;
      CMD_ZERO_ATT: zat         = 1'b1;
      CMD_BARO_CAL: bcal        = 1'b1;
      CMD_RESTART:  rst_req     = 1'b1;
      CMD_BEEP:     beep        = 1'b1;
      CMD_SERIAL:   serial_en_d = ~serial_en_q;
      default:      phase_cmd   = phase_q;
    endcase
  end

  // detection condition for the phase after the command
  always_comb begin
    case (phase_cmd)
      PH_ARMED:   cond = held_accel_d > cfg_i.liftoff_accel;
      PH_POWERED: cond = held_accel_d < cfg_i.burnout_accel;
      PH_COAST:   cond = $signed(held_vel_d) < $signed(cfg_i.apogee_vel);
      PH_DESCENT: cond = held_accel_d > cfg_i.chute_accel;
      PH_CHUTE:   cond = $signed(held_vel_d) > $signed(cfg_i.landing_vel);
      default:    cond = 1'b0;
    endcase
  end

  assign run   = gap_ok & (phase_cmd >= PH_ARMED) & (phase_cmd <= PH_CHUTE);
  assign limit = {1'b0, cfg_i.confirm_limit};

  // debounce tally
  always_comb begin
    phase_d = phase_cmd;
    tally_d = tally_q;
    if (run) begin
      if (cond && (tally_q <= limit)) begin
        tally_d = tally_q + 5'd1;
      end else if (tally_q >= limit) begin
        phase_d = phase_cmd + 3'd1;
        tally_d = '0;
      end else begin
        tally_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      tally_q       <= 5'd1;
      serial_en_q   <= 1'b0;
      sample_mark_q <= '0;
      telem_mark_q  <= '0;
      serial_mark_q <= '0;
      last_time_q   <= '0;
      held_accel_q  <= '0;
      held_vel_q    <= '0;
    end else if (step_en_i) begin
      phase_q       <= phase_d;
      tally_q       <= tally_d;
      serial_en_q   <= serial_en_d;
      sample_mark_q <= sample_mark_d;
      telem_mark_q  <= telem_mark_d;
      serial_mark_q <= serial_mark_d;
      last_time_q   <= time_ms_i;
      held_accel_q  <= held_accel_d;
      held_vel_q    <= held_vel_d;
    end
  end

  // result of this pass
  assign res_o = '{
    phase:             phase_d,
    tally_now:         tally_d,
    take_sample:       smp,
    send_telemetry:    tel,
    send_serial:       ser,
    serial_active:     serial_en_d,
    restart_req:       rst_req,
    zero_attitude_req: zat,
    baro_cal_req:      bcal,
    beep_req:          beep
  };

  // detection moves the phase by one step only, arming aside
  `FPS_ASSERT_NOW(a_phase_step, step_en_i && command_i != CMD_ARM && phase_d != phase_q,
    phase_d == phase_q + 3'd1, "phase jumped by more than one step")
  // serial strobe depends on the enable held before this pass
  `FPS_ASSERT_NEXT(a_serial_mark, step_en_i && !ser,
    $stable(serial_mark_q), "serial mark moved without a strobe")
  // tally never passes the largest limit plus one
  `FPS_ASSERT_NOW(a_tally_bound, 1'b1, tally_q <= 5'd16, "tally out of range")

endmodule

/* hw/rtl/flight_phase_sequencer.sv */
// top level of the flight phase sequencer: item register, pass logic, result register
// depends on fps_pkg, fps_cfg, fps_step and assert_macros.svh
//
// usage
//   one input item is one pass of the control loop: time, acceleration,
//   vertical velocity and a ground command byte. each item gives exactly one
//   result item: phase, tally, timer strobes, serial enable and request flags.
//   both channels use valid and stall; an item moves at a clock edge where
//   valid is high and stall is low.
//   an item is captured in the input register; the pass logic reads it there
//   and, once the result register is free, writes the state and the result
//   register, where out_valid_o rises. throughput is one item per cycle while
//   the receiver does not stall, set by the single state update per pass.
//   while the receiver stalls, the held result stays put and one more item
//   waits in the input register; only then does in_stall_o go high.
//   reset clears the phase to idle, the tally to one, the marks, the serial
//   enable and both registers, and loads the default thresholds. the user must
//   write thresholds on the apb-style port while no item is in flight; not enforced.
`include "assert_macros.svh"

module flight_phase_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fps_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fps_pkg::TIME_BITS-1:0] time_ms_i,
  input  logic [23:0]                   accel_mag_i,
  input  logic signed [23:0]            vert_vel_i,
  input  logic [7:0]                    command_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    phase_o,
  output logic [4:0]                    tally_now_o,
  output logic                          take_sample_o,
  output logic                          send_telemetry_o,
  output logic                          send_serial_o,
  output logic                          serial_active_o,
  output logic                          restart_req_o,
  output logic                          zero_attitude_req_o,
  output logic                          baro_cal_req_o,
  output logic                          beep_req_o
);
  import fps_pkg::*;

  cfg_t                  cfg;
  res_t                  res, res_q;
  logic                  in_valid_q, out_valid_q;
  logic [TIME_BITS-1:0]  time_q;
  logic [23:0]           accel_q;
  logic signed [23:0]    vel_q;
  logic [7:0]            cmd_q;
  logic                  out_ready, step_en;

  fps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake between the two registers
  assign out_ready  = ~out_valid_q | ~out_stall_i;
  assign step_en    = in_valid_q & out_ready;
  assign in_stall_o = in_valid_q & ~out_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      time_q  <= time_ms_i;
      accel_q <= accel_mag_i;
      vel_q   <= vert_vel_i;
      cmd_q   <= command_i;
    end
  end

  fps_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .time_ms_i   (time_q),
    .accel_mag_i (accel_q),
    .vert_vel_i  (vel_q),
    .command_i   (cmd_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign phase_o             = res_q.phase;
  assign tally_now_o         = res_q.tally_now;
  assign take_sample_o       = res_q.take_sample;
  assign send_telemetry_o    = res_q.send_telemetry;
  assign send_serial_o       = res_q.send_serial;
  assign serial_active_o     = res_q.serial_active;
  assign restart_req_o       = res_q.restart_req;
  assign zero_attitude_req_o = res_q.zero_attitude_req;
  assign baro_cal_req_o      = res_q.baro_cal_req;
  assign beep_req_o          = res_q.beep_req;

  // a held result is not overwritten
  `FPS_ASSERT_NEXT(a_hold_result, out_valid_q && out_stall_i,
    out_valid_q && $stable(res_q), "stalled result changed")
  // one command raises at most one request flag
  `FPS_ASSERT_NOW(a_one_request, out_valid_q,
    $onehot0({res_q.restart_req, res_q.zero_attitude_req, res_q.baro_cal_req, res_q.beep_req}),
    "more than one request flag")
  // input side stalls only with both registers full
  `FPS_ASSERT_NOW(a_stall_full, in_stall_o, in_valid_q && out_valid_q,
    "stall without a full pipeline")

endmodule

/* test/flight_phase_sequencer_tb.sv */
// self-checking testbench of flight_phase_sequencer: directed passes, then
// phase-aware random flights under several threshold settings and idling mixes
// depends on fps_pkg and the flight_phase_sequencer rtl
`timescale 1ns / 100ps

module flight_phase_sequencer_tb;
  import fps_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [7:0] CMD_NONE    = 8'd0;
  localparam logic [7:0] CMD_IGNORED = 8'd112;

  // tracks sequencer state per accepted item and checks result items in order
  class phase_scoreboard;
    logic        [23:0] liftoff_thr, burnout_thr, chute_thr;
    logic signed [23:0] apogee_thr, landing_thr;
    logic        [3:0]  confirm_max;
    logic        [15:0] gap_ms;
    logic        [2:0]  cur_phase;
    logic        [4:0]  tally;
    logic               serial_on;
    logic        [31:0] sample_mark, telem_mark, serial_mark, last_time;
    logic        [23:0] held_accel;
    logic signed [23:0] held_vel;
    res_t               due_results[$];
    int                 errors;

    function new();
      liftoff_thr = 24'd5120;
      burnout_thr = 24'd512;
      apogee_thr  = 24'sd1280;
      chute_thr   = 24'd1536;
      landing_thr = 24'sd768;
      confirm_max = 4'd4;
      gap_ms      = 16'd100;
      cur_phase   = PH_IDLE;
      tally       = 5'd1;
      serial_on   = 1'b0;
      sample_mark = '0;
      telem_mark  = '0;
      serial_mark = '0;
      last_time   = '0;
      held_accel  = '0;
      held_vel    = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_LIFTOFF_ACCEL: liftoff_thr = value[23:0];
        REG_BURNOUT_ACCEL: burnout_thr = value[23:0];
        REG_APOGEE_VEL:    apogee_thr  = value[23:0];
        REG_CHUTE_ACCEL:   chute_thr   = value[23:0];
        REG_LANDING_VEL:   landing_thr = value[23:0];
        REG_CONFIRM_LIMIT: confirm_max = value[3:0];
        REG_DETECT_GAP:    gap_ms      = value[15:0];
        default: ;
      endcase
    endfunction

    // count up while the condition holds, advance once the tally reached the bound
    function void debounce(bit hit, logic [2:0] next);
      if (hit && tally <= {1'b0, confirm_max}) begin
        tally = tally + 5'd1;
      end else if (tally >= {1'b0, confirm_max}) begin
        cur_phase = next;
        tally = '0;
      end else begin
        tally = '0;
      end
    endfunction

    function void note_pass(logic [31:0] t, logic [23:0] acc, logic signed [23:0] vel,
                            logic [7:0] cmd);
      logic [10:0] telem_ivl, sample_ivl, serial_ivl;
      res_t r;
      // intervals of the phase at the start of the pass
      case (cur_phase)
        PH_IDLE:  {telem_ivl, sample_ivl, serial_ivl} = {11'd1000, 11'd100, 11'd200};
        PH_ARMED: {telem_ivl, sample_ivl, serial_ivl} = {11'd50, 11'd20, 11'd100};
        PH_POWERED, PH_COAST, PH_DESCENT, PH_CHUTE:
          {telem_ivl, sample_ivl, serial_ivl} = {11'd20, 11'd20, 11'd100};
        default:  {telem_ivl, sample_ivl, serial_ivl} = {11'd20, 11'd100, 11'd200};
      endcase
      r = '0;
      // strobes: sample, then serial, then telemetry
      if ((t - sample_mark) > 32'(sample_ivl)) begin
        r.take_sample = 1'b1;
        sample_mark = t;
        held_accel = acc;
        held_vel = vel;
      end
      if ((t - serial_mark) > 32'(serial_ivl) && serial_on) begin
        r.send_serial = 1'b1;
        serial_mark = t;
      end
      if ((t - telem_mark) > 32'(telem_ivl)) begin
        r.send_telemetry = 1'b1;
        telem_mark = t;
      end
      // ground command
      case (cmd)
        CMD_ARM:      cur_phase = PH_ARMED;
        CMD_ZERO_ATT: r.zero_attitude_req = 1'b1;
        CMD_BARO_CAL: r.baro_cal_req = 1'b1;
        CMD_RESTART:  r.restart_req = 1'b1;
        CMD_BEEP:     r.beep_req = 1'b1;
        CMD_SERIAL:   serial_on = !serial_on;
        default: ;
      endcase
      // detection on the latched sensor values, only for closely spaced passes
      if ((t - last_time) < {16'd0, gap_ms}) begin
        case (cur_phase)
          PH_ARMED:   debounce(held_accel > liftoff_thr, PH_POWERED);
          PH_POWERED: debounce(held_accel < burnout_thr, PH_COAST);
          PH_COAST:   debounce(held_vel < apogee_thr, PH_DESCENT);
          PH_DESCENT: debounce(held_accel > chute_thr, PH_CHUTE);
          PH_CHUTE:   debounce(held_vel > landing_thr, PH_LANDED);
          default: ;
        endcase
      end
      last_time = t;
      r.phase = cur_phase;
      r.tally_now = tally;
      r.serial_active = serial_on;
      due_results.push_back(r);
    endfunction

    function void field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch %s at %0t: expected %0d, got %0d", name, $time, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result item with none pending at %0t", $time);
        return;
      end
      want = due_results.pop_front();
      field_ok("phase", 32'(want.phase), 32'(got.phase));
      field_ok("tally_now", 32'(want.tally_now), 32'(got.tally_now));
      field_ok("take_sample", 32'(want.take_sample), 32'(got.take_sample));
      field_ok("send_telemetry", 32'(want.send_telemetry), 32'(got.send_telemetry));
      field_ok("send_serial", 32'(want.send_serial), 32'(got.send_serial));
      field_ok("serial_active", 32'(want.serial_active), 32'(got.serial_active));
      field_ok("restart_req", 32'(want.restart_req), 32'(got.restart_req));
      field_ok("zero_attitude_req", 32'(want.zero_attitude_req),
               32'(got.zero_attitude_req));
      field_ok("baro_cal_req", 32'(want.baro_cal_req), 32'(got.baro_cal_req));
      field_ok("beep_req", 32'(want.beep_req), 32'(got.beep_req));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel, penable, pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [31:0]            pwdata, prdata;
  logic                   pready;
  logic                   in_valid_i, in_stall_o;
  logic [TIME_BITS-1:0]   time_ms_i;
  logic [23:0]            accel_mag_i;
  logic signed [23:0]     vert_vel_i;
  logic [7:0]             command_i;
  logic                   out_valid_o, out_stall_i;
  logic [2:0]             phase_o;
  logic [4:0]             tally_now_o;
  logic                   take_sample_o, send_telemetry_o, send_serial_o, serial_active_o;
  logic                   restart_req_o, zero_attitude_req_o, baro_cal_req_o, beep_req_o;

  phase_scoreboard sb;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  flight_phase_sequencer dut (.*);

  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // watch both channels at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_pass(time_ms_i, accel_mag_i, vert_vel_i, command_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result({phase_o, tally_now_o, take_sample_o, send_telemetry_o,
                         send_serial_o, serial_active_o, restart_req_o,
                         zero_attitude_req_o, baro_cal_req_o, beep_req_o});
    end
  end

  // offer one item, hold it until taken, then idle at random
  task automatic send_pass(input logic [31:0] t, input logic [23:0] acc,
                           input logic [23:0] vel, input logic [7:0] cmd);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    time_ms_i   <= t;
    accel_mag_i <= acc;
    vert_vel_i  <= vel;
    command_i   <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // stop offering and wait for every pending result item
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random flights: values mostly steer toward the next phase change
  task automatic run_flights(input int n_items, input logic [31:0] start);
    logic [31:0]        t_now;
    logic [23:0]        acc;
    logic signed [23:0] vel;
    logic [7:0]         cmd;
    int                 roll, bias, lim;
    t_now = start;
    for (int k = 0; k < n_items; k++) begin
      // time step: mostly short, sometimes past the detection gap or a jump
      roll = $urandom_range(99);
      if (roll < 3) t_now = $urandom;
      else if (roll < 8) t_now = t_now + sb.gap_ms + $urandom_range(50);
      else t_now = t_now + $urandom_range(35);
      acc = 24'($urandom);
      vel = 24'($urandom);
      bias = $urandom_range(9);
      if (bias < 7) begin
        case (sb.cur_phase)
          PH_ARMED:
            if (sb.liftoff_thr != 24'hFFFFFF)
              acc = 24'($urandom_range(24'hFFFFFF, sb.liftoff_thr + 1));
          PH_POWERED:
            if (sb.burnout_thr != 24'd0)
              acc = 24'($urandom_range(sb.burnout_thr - 1, 0));
          PH_COAST:
            if (sb.apogee_thr != 24'sh800000) begin
              lim = int'(sb.apogee_thr) + 8388607;
              vel = 24'(sb.apogee_thr - 24'sd1 - $urandom_range(lim));
            end
          PH_DESCENT:
            if (sb.chute_thr != 24'hFFFFFF)
              acc = 24'($urandom_range(24'hFFFFFF, sb.chute_thr + 1));
          PH_CHUTE:
            if (sb.landing_thr != 24'sh7FFFFF) begin
              lim = 8388606 - int'(sb.landing_thr);
              vel = 24'(sb.landing_thr + 24'sd1 + $urandom_range(lim));
            end
          default: ;
        endcase
      end else if (bias == 7) begin
        // values right on the thresholds
        roll = $urandom_range(2);
        acc = (roll == 0) ? sb.liftoff_thr : (roll == 1) ? sb.burnout_thr : sb.chute_thr;
        vel = $urandom_range(1) ? sb.apogee_thr : sb.landing_thr;
      end
      // commands: arm on the ground, rare re-arm, flags, toggles and noise
      roll = $urandom_range(99);
      if ((sb.cur_phase == PH_IDLE || sb.cur_phase == PH_LANDED) && roll < 20) begin
        cmd = CMD_ARM;
      end else if (roll < 1) begin
        cmd = CMD_ARM;
      end else if (roll < 4) begin
        cmd = 8'($urandom);
      end else if (roll < 9) begin
        case ($urandom_range(5))
          0: cmd = CMD_ZERO_ATT;
          1: cmd = CMD_BARO_CAL;
          2: cmd = CMD_RESTART;
          3: cmd = CMD_BEEP;
          4: cmd = CMD_SERIAL;
          default: cmd = CMD_IGNORED;
        endcase
      end else begin
        cmd = CMD_NONE;
      end
      send_pass(t_now, acc, vel, cmd);
    end
  endtask

  initial begin
    logic [31:0] setting [7];
    logic [31:0] start;
    sb = new();
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    time_ms_i   <= '0;
    accel_mag_i <= '0;
    vert_vel_i  <= '0;
    command_i   <= CMD_NONE;
    out_stall_i <= 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every command, then arm and climb to coast
    send_pass(32'd0, 24'd0, 24'd0, CMD_NONE);
    send_pass(32'd100, 24'hFFFFFF, 24'h800000, CMD_ZERO_ATT);
    send_pass(32'd101, 24'd0, 24'h7FFFFF, CMD_BARO_CAL);
    send_pass(32'd301, 24'd5120, 24'd0, CMD_RESTART);
    send_pass(32'd302, 24'd5120, 24'd0, CMD_BEEP);
    send_pass(32'd303, 24'd0, 24'd0, CMD_SERIAL);
    send_pass(32'd1002, 24'd0, 24'd0, CMD_IGNORED);
    send_pass(32'd1003, 24'd0, 24'd0, 8'hFF);
    send_pass(32'd1010, 24'hFFFFFF, 24'd0, CMD_ARM);
    for (int k = 0; k < 16; k++)
      send_pass(32'd1035 + 25 * k, (k < 6) ? 24'hFFFFFF : 24'd0,
                (k < 12) ? 24'd0 : 24'h800000, CMD_NONE);
    wait_drained();

    // threshold settings, each with one of four idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: setting = '{32'd0, 32'hFFFFFF, 32'h7FFFFF, 32'd0, 32'h800000, 32'd0, 32'd65535};
        2: setting = '{32'd100000, 32'd1000, 32'd0, 32'd3000, 32'hFFFF38, 32'd15,
                       32'd65535};
        3: setting = '{32'd5120, 32'd512, 32'd1280, 32'd1536, 32'd768, 32'd1, 32'd0};
        4: setting = '{32'hFFFFFF, 32'd0, 32'h800000, 32'hFFFFFF, 32'h7FFFFF, 32'd2, 32'd40};
        5: setting = '{$urandom_range(8000, 4000), $urandom_range(1000, 100),
                       ($urandom_range(2000) - 1000) & 32'hFFFFFF, $urandom_range(3000, 1000),
                       ($urandom_range(2000) - 1000) & 32'hFFFFFF, $urandom_range(15),
                       $urandom_range(200, 20)};
        6: setting = '{32'd5120, 32'd512, 32'd1280, 32'd1536, 32'd768, 32'd3, 32'd100};
        default: setting = '{$urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF,
                             $urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF,
                             $urandom & 32'hFFFFFF, $urandom_range(15),
                             $urandom_range(65535)};
      endcase
      if (ph != 0) begin
        write_reg(REG_LIFTOFF_ACCEL, setting[0]);
        write_reg(REG_BURNOUT_ACCEL, setting[1]);
        write_reg(REG_APOGEE_VEL, setting[2]);
        write_reg(REG_CHUTE_ACCEL, setting[3]);
        write_reg(REG_LANDING_VEL, setting[4]);
        write_reg(REG_CONFIRM_LIMIT, setting[5]);
        write_reg(REG_DETECT_GAP, setting[6]);
      end
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      start = (ph % 2 == 0) ? 32'hFFFF_F000 + $urandom_range(4095) : $urandom;
      if (ph == 0) begin
        // long receiver hold-off while items keep coming, then a full pause
        @(posedge clk_i);
        hold_left = 60;
        run_flights(20, start);
        wait_drained();
        run_flights(180, sb.last_time);
      end else begin
        run_flights(200, start);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* flight_phase_sequencer.f */
+incdir+hw/rtl
hw/rtl/fps_pkg.sv
hw/rtl/fps_cfg.sv
hw/rtl/fps_step.sv
hw/rtl/flight_phase_sequencer.sv
test/flight_phase_sequencer_tb.sv
